>>> rtl/audio_loop_recorder_assert.svh
// Assertion macros for the audio loop recorder, clocked on clk_i and reset by rst_ni.
`ifndef AUDIO_LOOP_RECORDER_ASSERT_SVH
`define AUDIO_LOOP_RECORDER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Checked outside reset only
`define ALR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked during reset as well
`define ALR_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define ALR_ASSERT(name, prop, msg)
`define ALR_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

>>> rtl/alr_pkg.sv
// Shared constants and types of the audio loop recorder.
package alr_pkg;

  // Default sizes
  localparam int unsigned LOOP_DEPTH_DEF  = 65536;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // Capacity register
  localparam int unsigned    CAP_BITS  = 17;
  localparam logic [16:0]    CAP_RESET = 17'd65536;

  // Input item codes
  localparam logic [1:0] IN_SAMPLE = 2'd0;
  localparam logic [1:0] IN_STOP   = 2'd1;
  localparam logic [1:0] IN_RECORD = 2'd2;
  localparam logic [1:0] IN_PLAY   = 2'd3;

  // Looper state codes
  localparam logic [1:0] LM_STOP   = 2'd0;
  localparam logic [1:0] LM_RECORD = 2'd1;
  localparam logic [1:0] LM_PLAY   = 2'd2;

  // Loop RAM access for one sample
  typedef struct packed {
    logic rd;
    logic wr;
  } alr_mem_req_t;

  // Flags of the item waiting for its RAM read data
  typedef struct packed {
    logic valid;
    logic add;
  } alr_s1_ctl_t;

endpackage

>>> rtl/alr_in_if.sv
// Input channel: a sample or a command per request.
interface alr_in_if
  import alr_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    mode;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output mode, output sample_in, input ready);
  modport sink   (input valid, input mode, input sample_in, output ready);
endinterface

>>> rtl/alr_out_if.sv
// Output channel: one mixed sample per request.
interface alr_out_if
  import alr_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [SAMPLE_BITS:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

>>> rtl/alr_loop_ram.sv
// Single-port loop sample RAM with registered read data.
module alr_loop_ram
  import alr_pkg::*;
#(
  parameter int unsigned LOOP_DEPTH  = LOOP_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                            clk_i,
  input  alr_mem_req_t                    req_i,
  input  logic [$clog2(LOOP_DEPTH)-1:0]   addr_i,
  input  logic [SAMPLE_BITS-1:0]          wdata_i,
  output logic [SAMPLE_BITS-1:0]          rdata_o
);

  logic [SAMPLE_BITS-1:0] mem [LOOP_DEPTH];
  logic [SAMPLE_BITS-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      mem[addr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.rd) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/alr_ctrl.sv
// Looper control: mode, position, length, capacity and the read-wait stage.
module alr_ctrl
  import alr_pkg::*;
#(
  parameter int unsigned LOOP_DEPTH  = LOOP_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [CAP_BITS-1:0]             cfg_wdata_i,
  input  logic                            accept_i,
  input  logic [1:0]                      mode_i,
  input  logic signed [SAMPLE_BITS-1:0]   sample_i,
  input  logic                            advance_i,
  output alr_mem_req_t                    mem_req_o,
  output logic [$clog2(LOOP_DEPTH)-1:0]   mem_addr_o,
  output logic [SAMPLE_BITS-1:0]          mem_wdata_o,
  output alr_s1_ctl_t                     s1_ctl_o,
  output logic signed [SAMPLE_BITS-1:0]   s1_sample_o
);

  `include "audio_loop_recorder_assert.svh"

  localparam int unsigned AW   = $clog2(LOOP_DEPTH);
  localparam int unsigned LW   = $clog2(LOOP_DEPTH + 1);
  localparam int unsigned CMPW = (LW > CAP_BITS) ? LW : CAP_BITS;

  logic [1:0]          mode_q, mode_d;
  logic [AW-1:0]       pos_q, pos_d;
  logic [LW-1:0]       len_q, len_d;
  logic [CAP_BITS-1:0] cap_q;
  alr_s1_ctl_t         s1_q, s1_d;
  logic signed [SAMPLE_BITS-1:0] s1_sample_q;

  logic          is_sample;
  logic [LW-1:0] pos_inc;
  logic          cap_hit;
  logic          play_add;

  assign is_sample = (mode_i == IN_SAMPLE);
  assign pos_inc   = LW'(pos_q) + LW'(1);
  assign play_add  = (mode_q == LM_PLAY) && (len_q != '0);

  // Recording stops at the capacity or the loop depth, a zero capacity acting as one
  assign cap_hit = (cap_q == '0) || (CMPW'(pos_inc) >= CMPW'(cap_q)) ||
                   (pos_inc == LW'(LOOP_DEPTH));

  // RAM access: write while recording, read while playing a non-empty loop
  always_comb begin
    mem_req_o.wr = accept_i && is_sample && (mode_q == LM_RECORD);
    mem_req_o.rd = accept_i && is_sample && play_add;
  end
  assign mem_addr_o  = pos_q;
  assign mem_wdata_o = sample_i;

  // Next looper state
  always_comb begin
    mode_d = mode_q;
    pos_d  = pos_q;
    len_d  = len_q;
    if (accept_i) begin
      if (!is_sample) begin
        pos_d = '0;
        unique case (mode_i)
          IN_STOP:   mode_d = LM_STOP;
          IN_RECORD: mode_d = LM_RECORD;
          default:   mode_d = LM_PLAY;
        endcase
      end else begin
        unique case (mode_q)
          LM_PLAY: begin
            pos_d = (pos_inc >= len_q) ? '0 : pos_inc[AW-1:0];
          end
          LM_RECORD: begin
            len_d = pos_inc;
            if (cap_hit) begin
              mode_d = LM_PLAY;
              pos_d  = '0;
            end else begin
              pos_d = pos_inc[AW-1:0];
            end
          end
          default: begin
            pos_d = pos_q;
          end
        endcase
      end
    end
  end

  // Read-wait stage: filled by a sample, drained when the output takes it
  always_comb begin
    s1_d = s1_q;
    if (accept_i && is_sample) begin
      s1_d.valid = 1'b1;
      s1_d.add   = play_add;
    end else if (advance_i) begin
      s1_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= LM_STOP;
      pos_q  <= '0;
      len_q  <= '0;
      cap_q  <= CAP_RESET;
      s1_q   <= '0;
    end else begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      len_q  <= len_d;
      s1_q   <= s1_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // Sample payload needs no reset
  always_ff @(posedge clk_i) begin
    if (accept_i && is_sample) begin
      s1_sample_q <= sample_i;
    end
  end

  assign s1_ctl_o    = s1_q;
  assign s1_sample_o = s1_sample_q;

  `ALR_ASSERT(a_pos_in_loop, (mode_q == LM_PLAY && len_q != '0) |-> (LW'(pos_q) < len_q), "play position outside loop")
  `ALR_ASSERT(a_rd_wr_excl, !(mem_req_o.rd && mem_req_o.wr), "loop RAM read and write together")
  `ALR_ASSERT(a_len_follows_wr, mem_req_o.wr |=> (len_q == LW'($past(pos_q)) + LW'(1)), "loop length not updated by record")
  `ALR_ASSERT_ALWAYS(a_no_add_when_empty, (s1_q.valid && s1_q.add) |-> (len_q != '0 || !rst_ni), "loop added while empty")

endmodule

>>> rtl/audio_loop_recorder.sv
// A sample's result passes the read stage (RAM read) and then the output register.
// Throughput: one request per cycle unless the output stalls; each sample uses the single
// loop RAM port at most once. Commands give no result.
// Reset (rst_ni, asynchronous): mode stop, position and length zero, capacity 65536.
// The loop RAM is not cleared: it needs no clearing pass, and is only read at recorded entries.
module audio_loop_recorder
  import alr_pkg::*;
#(
  parameter int unsigned LOOP_DEPTH  = LOOP_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CAP_BITS-1:0] cfg_wdata_i,
  alr_in_if.sink              in_i,
  alr_out_if.source           out_o
);

  localparam int unsigned AW = $clog2(LOOP_DEPTH);

  alr_mem_req_t           mem_req;
  logic [AW-1:0]          mem_addr;
  logic [SAMPLE_BITS-1:0] mem_wdata;
  logic [SAMPLE_BITS-1:0] mem_rdata;
  alr_s1_ctl_t            s1_ctl;
  logic signed [SAMPLE_BITS-1:0] s1_sample;

  logic accept;
  logic advance;
  logic out_valid_q, out_valid_d;
  logic signed [SAMPLE_BITS:0] out_sample_q, mix;

  // Output register frees when empty or taken; the read stage moves into it then
  assign advance     = !out_valid_q || out_o.ready;
  assign in_i.ready  = !s1_ctl.valid || advance;
  assign accept      = in_i.valid && in_i.ready;

  alr_ctrl #(
    .LOOP_DEPTH  (LOOP_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .mode_i      (in_i.mode),
    .sample_i    (in_i.sample_in),
    .advance_i   (advance),
    .mem_req_o   (mem_req),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .s1_ctl_o    (s1_ctl),
    .s1_sample_o (s1_sample)
  );

  alr_loop_ram #(
    .LOOP_DEPTH  (LOOP_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // Mix input with the loop sample, no saturation
  assign mix = {s1_sample[SAMPLE_BITS-1], s1_sample} +
               (s1_ctl.add ? {mem_rdata[SAMPLE_BITS-1], mem_rdata} : '0);

  assign out_valid_d = advance ? s1_ctl.valid : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_ctl.valid) begin
      out_sample_q <= mix;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_sample_q;

endmodule

>>> tb/tb_audio_loop_recorder.sv
// Self-checking testbench for the audio loop recorder: directed and random requests.
`timescale 1ns / 1ps

module tb_audio_loop_recorder;
  import alr_pkg::*;

  localparam int unsigned DEPTH       = LOOP_DEPTH_DEF;
  localparam int unsigned LIMIT_CYCLE = 2000000;
  localparam int unsigned TAIL_CYCLES = 6;
  localparam int unsigned MAX_REPORTS = 40;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CAP_BITS-1:0] cfg_wdata;

  alr_in_if  #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) in_if ();
  alr_out_if #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) out_if ();

  audio_loop_recorder #(
    .LOOP_DEPTH (DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS_DEF)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Looper shadow state
  logic [1:0]          looper_st;
  int unsigned         play_pos;
  int unsigned         rec_len;
  logic [CAP_BITS-1:0] cap_reg;
  logic [15:0]         loop_ram [DEPTH];

  logic signed [16:0] expected_mix_q [$];
  logic signed [16:0] exp_mix;

  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned sent_cnt;
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Timeout
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLE) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver backpressure
  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Result checker: compare each taken result against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_mix_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("%0t: unexpected result: expected none, actual %0d",
                   $time, out_if.sample_out);
      end else begin
        exp_mix = expected_mix_q.pop_front();
        if (out_if.sample_out !== exp_mix) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                     $time, exp_mix, out_if.sample_out);
        end
      end
    end
  end

  function automatic int unsigned eff_capacity();
    int unsigned c;
    c = cap_reg;
    if (c == 0) c = 1;
    if (c > DEPTH) c = DEPTH;
    return c;
  endfunction

  // Advance the looper for one request, queue the mix for a sample
  task automatic predict_mix(input logic [1:0] code, input logic signed [15:0] smp);
    logic signed [16:0] mix;
    if (code != IN_SAMPLE) begin
      case (code)
        IN_STOP:   looper_st = LM_STOP;
        IN_RECORD: looper_st = LM_RECORD;
        default:   looper_st = LM_PLAY;
      endcase
      play_pos = 0;
      return;
    end
    mix = smp;
    if (looper_st == LM_PLAY) begin
      // empty loop adds nothing and holds position 0
      if (rec_len != 0) mix = smp + $signed(loop_ram[play_pos]);
      play_pos++;
      if (play_pos >= rec_len) play_pos = 0;
    end else if (looper_st == LM_RECORD) begin
      loop_ram[play_pos] = smp;
      rec_len = play_pos + 1;
      play_pos++;
      if (play_pos >= eff_capacity()) begin
        looper_st = LM_PLAY;
        play_pos  = 0;
      end
    end
    expected_mix_q.push_back(mix);
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      default: return 16'($urandom());
    endcase
  endfunction

  // Send one request, with random sender gaps before it
  task automatic send_req(input logic [1:0] code, input logic signed [15:0] smp);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.mode      <= code;
    in_if.sample_in <= smp;
    do @(posedge clk); while (!in_if.ready);
    predict_mix(code, smp);
    sent_cnt++;
  endtask

  task automatic send_cmd(input logic [1:0] code);
    send_req(code, rand_sample());
  endtask

  // Hold requests until every predicted result has been taken
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (expected_mix_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_BITS-1:0] val);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cap_reg = val;
    cfg_we <= 1'b0;
  endtask

  task automatic set_idle(input int unsigned tx_pct, input int unsigned rx_pct);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
  endtask

  // Play before anything was recorded
  task automatic test_empty_loop();
    send_cmd(IN_PLAY);
    send_req(IN_SAMPLE, 16'sh7FFF);
    send_req(IN_SAMPLE, 16'sh8000);
    send_req(IN_SAMPLE, 16'sh0001);
  endtask

  // Stop mode passes samples through
  task automatic test_passthrough();
    send_cmd(IN_STOP);
    send_req(IN_SAMPLE, 16'sh8000);
    send_req(IN_SAMPLE, 16'sh7FFF);
    send_req(IN_SAMPLE, 16'sh0000);
    send_req(IN_SAMPLE, 16'shFFFF);
    send_req(IN_SAMPLE, 16'sh5555);
    send_req(IN_SAMPLE, 16'shAAAA);
  endtask

  // Record a short loop, play it at the sum extremes, then fill to capacity
  task automatic test_record_play();
    set_capacity(17'd3);
    send_cmd(IN_RECORD);
    send_req(IN_SAMPLE, 16'sh8000);
    send_req(IN_SAMPLE, 16'sh7FFF);
    send_cmd(IN_PLAY);
    send_req(IN_SAMPLE, 16'sh8000);
    send_req(IN_SAMPLE, 16'sh7FFF);
    send_req(IN_SAMPLE, 16'sh0000);
    send_cmd(IN_RECORD);
    repeat (3) send_req(IN_SAMPLE, rand_sample());
    repeat (4) send_req(IN_SAMPLE, rand_sample());
  endtask

  // Capacity zero and one, capacity lowered under the record position
  task automatic test_capacity_edges();
    set_capacity(17'd0);
    send_cmd(IN_RECORD);
    repeat (3) send_req(IN_SAMPLE, rand_sample());
    set_capacity(17'd1);
    send_cmd(IN_RECORD);
    repeat (2) send_req(IN_SAMPLE, rand_sample());
    set_capacity(17'd8);
    send_cmd(IN_RECORD);
    repeat (3) send_req(IN_SAMPLE, rand_sample());
    set_capacity(17'd2);
    repeat (3) send_req(IN_SAMPLE, rand_sample());
  endtask

  // Reset capacity and a capacity above the depth: recording runs until a command
  task automatic test_large_capacity();
    send_cmd(IN_RECORD);
    repeat (10) send_req(IN_SAMPLE, rand_sample());
    send_cmd(IN_PLAY);
    repeat (12) send_req(IN_SAMPLE, rand_sample());
    set_capacity(17'h1FFFF);
    send_cmd(IN_RECORD);
    repeat (8) send_req(IN_SAMPLE, rand_sample());
    send_cmd(IN_PLAY);
    repeat (10) send_req(IN_SAMPLE, rand_sample());
  endtask

  function automatic logic [CAP_BITS-1:0] rand_capacity();
    case ($urandom_range(9))
      0:       return 17'd0;
      1:       return 17'd1;
      2:       return 17'($urandom());
      default: return 17'($urandom_range(2, 16));
    endcase
  endfunction

  // Random record / play sessions with noise, over one idle setting
  task automatic test_random_phase(input int unsigned tx_pct, input int unsigned rx_pct,
                                   input int unsigned n_items);
    int unsigned stop_at;
    int unsigned k;
    set_capacity(rand_capacity());
    set_idle(tx_pct, rx_pct);
    stop_at = sent_cnt + n_items;
    while (sent_cnt < stop_at) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: begin
          send_cmd(IN_RECORD);
          repeat ($urandom_range(1, 12)) send_req(IN_SAMPLE, rand_sample());
          send_cmd(IN_PLAY);
          repeat ($urandom_range(1, 20)) send_req(IN_SAMPLE, rand_sample());
        end
        5: begin
          send_cmd(IN_STOP);
          repeat ($urandom_range(1, 6)) send_req(IN_SAMPLE, rand_sample());
        end
        6, 7: begin
          repeat ($urandom_range(1, 8)) send_req(2'($urandom()), rand_sample());
        end
        8: begin
          // lower the capacity while a recording is under way
          k = $urandom_range(1, 6);
          send_cmd(IN_RECORD);
          repeat (k) send_req(IN_SAMPLE, rand_sample());
          set_capacity(17'($urandom_range(0, k)));
          repeat ($urandom_range(1, 6)) send_req(IN_SAMPLE, rand_sample());
        end
        default: begin
          repeat ($urandom_range(1, 10)) send_req(IN_SAMPLE, rand_sample());
        end
      endcase
    end
  endtask

  // Main sequence
  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_if.valid     = 1'b0;
    in_if.mode      = IN_SAMPLE;
    in_if.sample_in = '0;
    out_if.ready    = 1'b0;
    err_cnt         = 0;
    cycle_cnt       = 0;
    sent_cnt        = 0;
    looper_st       = LM_STOP;
    play_pos        = 0;
    rec_len         = 0;
    cap_reg         = CAP_RESET;
    set_idle(0, 0);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_loop();
    test_passthrough();
    test_large_capacity();
    set_idle(0, 30);
    test_record_play();
    test_capacity_edges();
    test_random_phase(0, 0, 135);
    test_random_phase(71, 0, 135);
    test_random_phase(0, 71, 135);
    test_random_phase(31, 31, 135);

    wait_drained();
    if (expected_mix_q.size() != 0) err_cnt++;
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/alr_pkg.sv
rtl/alr_in_if.sv
rtl/alr_out_if.sv
rtl/alr_loop_ram.sv
rtl/alr_ctrl.sv
rtl/audio_loop_recorder.sv
tb/tb_audio_loop_recorder.sv
